FILE: src/wsdf_pkg.sv
`default_nettype none

package wsdf_pkg;

   // field widths
   localparam int DATA_W = 8;
   localparam int LEN_W  = 64;
   localparam int KEY_W  = 32;
   localparam int CNT_W  = 4;

   // header parse phases
   typedef enum logic [2:0] {
      PH_B0,
      PH_B1,
      PH_EXT16,
      PH_EXT64,
      PH_MASK,
      PH_DATA
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_PROTO = 2'd1;
   localparam logic [1:0] ST_CTRL  = 2'd2;

   // header constants
   localparam logic [7:0]       RSV_BITS     = 8'h70;
   localparam logic [3:0]       OPC_CTRL_BIT = 4'h8;
   localparam logic [3:0]       OPC_RSV_LO   = 4'h3;
   localparam logic [3:0]       OPC_RSV_MID  = 4'h7;
   localparam logic [3:0]       OPC_RSV_HI   = 4'hB;
   localparam logic [6:0]       LEN7_EXT16   = 7'd126;
   localparam logic [6:0]       LEN7_EXT64   = 7'd127;
   localparam logic [6:0]       CTRL_MAX_LEN = 7'd125;
   localparam logic [LEN_W-1:0] MIN_LEN16    = 64'd126;
   localparam logic [LEN_W-1:0] MAX_SHORT64  = 64'hFFFF;
   localparam logic [CNT_W-1:0] EXT16_BYTES  = 4'd2;
   localparam logic [CNT_W-1:0] EXT64_BYTES  = 4'd8;
   localparam logic [CNT_W-1:0] KEY_BYTES    = 4'd4;

   // one result item
   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        status;
      logic [3:0]        opcode;
      logic              fin;
      logic [LEN_W-1:0]  frame_len;
      logic [DATA_W-1:0] payload_byte;
      logic              last_byte;
   } rsp_type;

   // opcodes 3..7 and 11..15 are reserved
   function automatic logic is_reserved_op(input logic [3:0] op);
      is_reserved_op = ((op >= OPC_RSV_LO) && (op <= OPC_RSV_MID)) || (op >= OPC_RSV_HI);
   endfunction

endpackage

`default_nettype wire

FILE: src/wsdf_req_if.sv
`default_nettype none

interface wsdf_req_if;
   import wsdf_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);

endinterface

`default_nettype wire

FILE: src/wsdf_rsp_if.sv
`default_nettype none

interface wsdf_rsp_if;
   import wsdf_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [1:0]        status;
   logic [3:0]        opcode;
   logic              fin;
   logic [LEN_W-1:0]  frame_len;
   logic [DATA_W-1:0] payload_byte;
   logic              last_byte;

   modport source (output valid, output kind, output status, output opcode, output fin,
                   output frame_len, output payload_byte, output last_byte, input ready);
   modport sink   (input valid, input kind, input status, input opcode, input fin,
                   input frame_len, input payload_byte, input last_byte, output ready);

endinterface

`default_nettype wire

FILE: src/websocket_frame_deframer.sv
// a byte is held in the input register and its item in the result register
// throughput: one byte per cycle unless the output stalls, set by the single
//   parse stage between input and result registers, which advance together
// reset (synchronous): parser waits for the first header byte, all parser
//   state, halt flag and both stage valid flags cleared; no clearing pass
`default_nettype none

module websocket_frame_deframer (
   input wire logic   clock,
   input wire logic   reset,
   wsdf_req_if.sink   req_chan,
   wsdf_rsp_if.source rsp_chan
);
   import wsdf_pkg::*;

   // input stage
   logic              in_valid_ff;
   logic [DATA_W-1:0] in_byte_ff;

   // parser state
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  header_count_ff, header_count_in;
   logic [7:0]        first_byte_ff, first_byte_in;
   logic [LEN_W-1:0]  length_accum_ff, length_accum_in;
   logic [KEY_W-1:0]  xor_key_ff, xor_key_in;
   logic [LEN_W-1:0]  remaining_ff, remaining_in;
   logic [1:0]        mask_index_ff, mask_index_in;
   logic              halted_ff, halted_in;

   // result stage
   logic              out_valid_ff;
   rsp_type           out_ff;

   logic              out_free;
   logic              advance;
   logic              work;
   logic              res_valid;
   rsp_type           res;

   // decode of the current byte
   logic [DATA_W-1:0] b;
   logic [6:0]        len7;
   logic              err_rsv, err_op, err_ctrl, err_mask, b1_err;
   logic [1:0]        b1_status;
   logic [LEN_W-1:0]  accum_shift;
   logic [CNT_W-1:0]  count_inc;
   logic              ext_done, ext_err, key_done, last;
   logic [4:0]        key_wr_pos, key_rd_pos;

   // handshake
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign work           = advance && !halted_ff;
   assign req_chan.ready = !in_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
      end
   end

   // header checks and length / key arithmetic
   always_comb begin
      b           = in_byte_ff;
      len7        = b[6:0];
      err_rsv     = (first_byte_ff & RSV_BITS) != 8'h00;
      err_op      = is_reserved_op(first_byte_ff[3:0]);
      err_ctrl    = ((first_byte_ff[3:0] & OPC_CTRL_BIT) != 4'h0)
                    && (!first_byte_ff[7] || (len7 > CTRL_MAX_LEN));
      err_mask    = !b[7];
      b1_err      = err_rsv || err_op || err_ctrl || err_mask;
      b1_status   = (!err_rsv && !err_op && err_ctrl) ? ST_CTRL : ST_PROTO;
      accum_shift = {length_accum_ff[LEN_W-DATA_W-1:0], b};
      count_inc   = header_count_ff + 4'd1;
      ext_done    = ((phase_ff == PH_EXT16) && (count_inc == EXT16_BYTES))
                    || ((phase_ff == PH_EXT64) && (count_inc == EXT64_BYTES));
      ext_err     = (phase_ff == PH_EXT16) ? (accum_shift < MIN_LEN16)
                                           : (accum_shift <= MAX_SHORT64);
      key_done    = count_inc == KEY_BYTES;
      last        = remaining_ff == 64'd1;
      key_wr_pos  = {header_count_ff[1:0], 3'b000};
      key_rd_pos  = {mask_index_ff, 3'b000};
   end

   // next state
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      first_byte_in   = first_byte_ff;
      length_accum_in = length_accum_ff;
      xor_key_in      = xor_key_ff;
      remaining_in    = remaining_ff;
      mask_index_in   = mask_index_ff;
      halted_in       = halted_ff;
      if (work) begin
         unique case (phase_ff)
            PH_B1: begin
               if (b1_err) begin
                  halted_in = 1'b1;
               end else begin
                  header_count_in = '0;
                  length_accum_in = '0;
                  if (len7 == LEN7_EXT16) begin
                     phase_in = PH_EXT16;
                  end else if (len7 == LEN7_EXT64) begin
                     phase_in = PH_EXT64;
                  end else begin
                     length_accum_in = {{(LEN_W-7){1'b0}}, len7};
                     phase_in        = PH_MASK;
                  end
               end
            end
            PH_EXT16, PH_EXT64: begin
               length_accum_in = accum_shift;
               header_count_in = count_inc;
               if (ext_done) begin
                  if (ext_err) begin
                     halted_in = 1'b1;
                  end else begin
                     header_count_in = '0;
                     phase_in        = PH_MASK;
                  end
               end
            end
            PH_MASK: begin
               xor_key_in[key_wr_pos +: 8] = xor_key_ff[key_wr_pos +: 8] | b;
               header_count_in = count_inc;
               if (key_done) begin
                  header_count_in = '0;
                  remaining_in    = length_accum_ff;
                  mask_index_in   = '0;
                  phase_in        = (length_accum_ff == '0) ? PH_B0 : PH_DATA;
               end
            end
            PH_DATA: begin
               remaining_in  = remaining_ff - 64'd1;
               mask_index_in = mask_index_ff + 2'd1;
               if (last) begin
                  phase_in = PH_B0;
               end
            end
            default: begin
               first_byte_in   = b;
               xor_key_in      = '0;
               header_count_in = '0;
               phase_in        = PH_B1;
            end
         endcase
      end
   end

   // result item
   always_comb begin
      res_valid        = 1'b0;
      res.kind         = KIND_HEADER;
      res.status       = ST_OK;
      res.opcode       = first_byte_ff[3:0];
      res.fin          = first_byte_ff[7];
      res.frame_len    = '0;
      res.payload_byte = '0;
      res.last_byte    = 1'b0;
      if (work) begin
         unique case (phase_ff)
            PH_B1: begin
               if (b1_err) begin
                  res_valid  = 1'b1;
                  res.kind   = KIND_ERROR;
                  res.status = b1_status;
               end
            end
            PH_EXT16, PH_EXT64: begin
               if (ext_done && ext_err) begin
                  res_valid  = 1'b1;
                  res.kind   = KIND_ERROR;
                  res.status = ST_PROTO;
               end
            end
            PH_MASK: begin
               if (key_done) begin
                  res_valid     = 1'b1;
                  res.kind      = KIND_HEADER;
                  res.frame_len = length_accum_ff;
               end
            end
            PH_DATA: begin
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.frame_len    = length_accum_ff;
               res.payload_byte = b ^ xor_key_ff[key_rd_pos +: 8];
               res.last_byte    = last;
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_B0;
         header_count_ff <= '0;
         first_byte_ff   <= '0;
         length_accum_ff <= '0;
         xor_key_ff      <= '0;
         remaining_ff    <= '0;
         mask_index_ff   <= '0;
         halted_ff       <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         first_byte_ff   <= first_byte_in;
         length_accum_ff <= length_accum_in;
         xor_key_ff      <= xor_key_in;
         remaining_ff    <= remaining_in;
         mask_index_ff   <= mask_index_in;
         halted_ff       <= halted_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_ff.kind;
   assign rsp_chan.status       = out_ff.status;
   assign rsp_chan.opcode       = out_ff.opcode;
   assign rsp_chan.fin          = out_ff.fin;
   assign rsp_chan.frame_len    = out_ff.frame_len;
   assign rsp_chan.payload_byte = out_ff.payload_byte;
   assign rsp_chan.last_byte    = out_ff.last_byte;

   // once halted no further item is produced
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !res_valid)
      else $error("result produced while halted");

   // an error item always leaves the parser halted
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid && (res.kind == KIND_ERROR)) |=> halted_ff)
      else $error("error item without halt");

   // payload phase never runs with nothing left to deliver
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (remaining_ff != '0))
      else $error("payload phase with zero bytes remaining");

   // the last flag only marks payload items
   a_last_payload: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last_byte) |-> (out_ff.kind == KIND_PAYLOAD))
      else $error("last flag on a non-payload item");

endmodule

`default_nettype wire
